[rtl/core/websocket_frame_decoder_defines.svh]
// ----------------------------------------------------------------------------
// websocket_frame_decoder_defines
// Assertion macros used by the websocket frame decoder result queue.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DECODER_DEFINES_SVH
`define WEBSOCKET_FRAME_DECODER_DEFINES_SVH

// Property must hold at every rising clock edge outside reset.
`define WFD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define WFD_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[rtl/core/wfd_pkg.sv]
// ----------------------------------------------------------------------------
// wfd_pkg
// Types and constants shared by the websocket frame decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wfd_pkg;

  localparam int unsigned LEN_W   = 64;
  localparam int unsigned LIMIT_W = 63;
  localparam int unsigned QDEPTH  = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10 * 1024 * 1024);

  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Header byte counter values at which a field is complete (3-bit wrap).
  localparam logic [2:0] EXT16_DONE = 3'd2;
  localparam logic [2:0] EXT64_DONE = 3'd0;
  localparam logic [2:0] MASK_DONE  = 3'd4;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT16   = 3'd2,
    PH_EXT64   = 3'd3,
    PH_MASK    = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_EMPTY    = 3'd1,
    KIND_PONG     = 3'd2,
    KIND_CLOSE    = 3'd3,
    KIND_OVERSIZE = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] raw;
    logic [7:0] key;
    logic [3:0] opcode;
    logic       last;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

`default_nettype wire

[rtl/core/websocket_frame_decoder.sv]
// Results pass from the parser through the result queue into the output register.
// Throughput: one byte per cycle; the parser takes a byte whenever the queue has room.
// in_ready drops only when the two-entry result queue is full.
// Reset clears the parser to wait for a first header byte and the limit to 10485760.
// Configuration writes complete in the cycle they are presented.
// ----------------------------------------------------------------------------
// websocket_frame_decoder
// Byte-serial frame parser: header decode, unmasking, control and oversize
// events, with a queued output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_decoder
  import wfd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_byte,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [LIMIT_W-1:0] max_payload_len,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              result_kind,
  output logic [7:0]              data_byte,
  output logic [3:0]              frame_opcode,
  output logic                    last
);

  qstat_t qstat;
  logic   push;
  entry_t push_entry;
  logic   pop;
  entry_t pop_entry;

  wfd_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .max_payload_len (max_payload_len),
    .qstat           (qstat),
    .push            (push),
    .push_entry      (push_entry)
  );

  wfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .qstat      (qstat)
  );

  wfd_out u_out (
    .clk          (clk),
    .rst          (rst),
    .qstat        (qstat),
    .pop_entry    (pop_entry),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .data_byte    (data_byte),
    .frame_opcode (frame_opcode),
    .last         (last)
  );

endmodule

`default_nettype wire

[rtl/core/wfd_parser.sv]
// ----------------------------------------------------------------------------
// wfd_parser
// Front end: takes stream bytes, walks the frame header, tracks the payload
// and pushes one classified result entry per byte that yields a result.
// ----------------------------------------------------------------------------
`default_nettype none

module wfd_parser
  import wfd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_byte,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [LIMIT_W-1:0] max_payload_len,
  input  wire qstat_t             qstat,
  output logic                    push,
  output entry_t                  push_entry
);

  phase_t             phase, phase_next;
  logic [3:0]         cur_opcode, cur_opcode_next;
  logic               mask_present, mask_present_next;
  logic [LEN_W-1:0]   remaining_len, remaining_len_next;
  logic [2:0]         hdr_count, hdr_count_next;
  logic [31:0]        mask_key, mask_key_next;
  logic [1:0]         key_index, key_index_next;
  logic               skipping, skipping_next;
  logic [LIMIT_W-1:0] limit;

  logic               fire;
  logic [2:0]         count_inc;
  logic [LEN_W-1:0]   len_shift;
  logic [LEN_W-1:0]   len_sel;
  logic               mask_sel;
  logic               do_after;
  logic               do_finish;
  logic               len_over;
  logic               pay_end;
  logic [7:0]         key_byte;
  kind_t              ctrl_kind;

  assign in_ready  = !qstat.full;
  assign cfg_ready = 1'b1;
  assign fire      = in_valid && in_ready;
  assign count_inc = hdr_count + 3'd1;
  assign len_shift = {remaining_len[LEN_W-9:0], in_byte};
  assign pay_end   = (remaining_len <= LEN_W'(1));

  always_comb begin
    case (key_index)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    if (cur_opcode == OP_PING) begin
      ctrl_kind = KIND_PONG;
    end else if (cur_opcode == OP_CLOSE) begin
      ctrl_kind = KIND_CLOSE;
    end else begin
      ctrl_kind = KIND_EMPTY;
    end
  end

  always_comb begin
    phase_next         = phase;
    cur_opcode_next    = cur_opcode;
    mask_present_next  = mask_present;
    remaining_len_next = remaining_len;
    hdr_count_next     = hdr_count;
    mask_key_next      = mask_key;
    key_index_next     = key_index;
    skipping_next      = skipping;
    len_sel            = remaining_len;
    mask_sel           = mask_present;
    do_after           = 1'b0;
    do_finish          = 1'b0;
    push               = 1'b0;
    push_entry.kind    = KIND_DATA;
    push_entry.raw     = 8'd0;
    push_entry.key     = 8'd0;
    push_entry.opcode  = cur_opcode;
    push_entry.last    = 1'b0;

    if (fire) begin
      case (phase)
        PH_HDR0: begin
          cur_opcode_next    = in_byte[3:0];
          mask_present_next  = 1'b0;
          mask_key_next      = 32'd0;
          key_index_next     = 2'd0;
          skipping_next      = 1'b0;
          remaining_len_next = '0;
          hdr_count_next     = 3'd0;
          phase_next         = PH_HDR1;
        end
        PH_HDR1: begin
          mask_present_next  = in_byte[7];
          hdr_count_next     = 3'd0;
          remaining_len_next = '0;
          if (in_byte[6:0] == LEN_EXT16) begin
            phase_next = PH_EXT16;
          end else if (in_byte[6:0] == LEN_EXT64) begin
            phase_next = PH_EXT64;
          end else begin
            remaining_len_next = LEN_W'(in_byte[6:0]);
            len_sel            = LEN_W'(in_byte[6:0]);
            mask_sel           = in_byte[7];
            do_after           = 1'b1;
          end
        end
        PH_EXT16, PH_EXT64: begin
          remaining_len_next = len_shift;
          hdr_count_next     = count_inc;
          len_sel            = len_shift;
          if ((phase == PH_EXT16) ? (count_inc == EXT16_DONE) : (count_inc == EXT64_DONE)) begin
            do_after = 1'b1;
          end
        end
        PH_MASK: begin
          mask_key_next  = {mask_key[23:0], in_byte};
          hdr_count_next = count_inc;
          if (count_inc == MASK_DONE) begin
            do_finish = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          key_index_next = key_index + 2'd1;
          if (remaining_len != '0) begin
            remaining_len_next = remaining_len - LEN_W'(1);
          end
          if (pay_end) begin
            phase_next = PH_HDR0;
          end
          if (skipping) begin
            if (pay_end) begin
              skipping_next = 1'b0;
            end
          end else if (cur_opcode == OP_PING || cur_opcode == OP_CLOSE) begin
            if (pay_end) begin
              push            = 1'b1;
              push_entry.kind = ctrl_kind;
              push_entry.last = 1'b1;
            end
          end else begin
            push            = 1'b1;
            push_entry.kind = KIND_DATA;
            push_entry.raw  = in_byte;
            push_entry.key  = key_byte;
            push_entry.last = pay_end;
          end
        end
        default: begin
          phase_next = PH_HDR0;
        end
      endcase
    end

    if (do_after) begin
      hdr_count_next = 3'd0;
      if (mask_sel) begin
        phase_next = PH_MASK;
      end else begin
        do_finish = 1'b1;
      end
    end

    len_over = (len_sel > {1'b0, limit});

    if (do_finish) begin
      key_index_next = 2'd0;
      hdr_count_next = 3'd0;
      if (len_over) begin
        skipping_next   = 1'b1;
        phase_next      = PH_PAYLOAD;
        push            = 1'b1;
        push_entry.kind = KIND_OVERSIZE;
        push_entry.last = 1'b1;
      end else if (len_sel == '0) begin
        phase_next      = PH_HDR0;
        push            = 1'b1;
        push_entry.kind = ctrl_kind;
        push_entry.last = 1'b1;
      end else begin
        phase_next = PH_PAYLOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HDR0;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_opcode    <= 4'd0;
      mask_present  <= 1'b0;
      remaining_len <= '0;
      hdr_count     <= 3'd0;
      mask_key      <= 32'd0;
      key_index     <= 2'd0;
      skipping      <= 1'b0;
    end else begin
      cur_opcode    <= cur_opcode_next;
      mask_present  <= mask_present_next;
      remaining_len <= remaining_len_next;
      hdr_count     <= hdr_count_next;
      mask_key      <= mask_key_next;
      key_index     <= key_index_next;
      skipping      <= skipping_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit <= max_payload_len;
    end
  end

endmodule

`default_nettype wire

[rtl/core/wfd_queue.sv]
// ----------------------------------------------------------------------------
// wfd_queue
// Short result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "websocket_frame_decoder_defines.svh"

module wfd_queue
  import wfd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output entry_t      pop_entry,
  output qstat_t      qstat
);

  localparam int unsigned QIDX_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  entry_t              slots [QDEPTH];
  logic [QIDX_W-1:0]   wr_ptr, wr_ptr_next;
  logic [QIDX_W-1:0]   rd_ptr, rd_ptr_next;
  logic [QCNT_W-1:0]   count, count_next;

  assign qstat.full  = (count == QCNT_W'(QDEPTH));
  assign qstat.empty = (count == '0);
  assign pop_entry   = slots[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == QIDX_W'(QDEPTH - 1)) ? '0 : wr_ptr + QIDX_W'(1);
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == QIDX_W'(QDEPTH - 1)) ? '0 : rd_ptr + QIDX_W'(1);
    end
    if (push && !pop) begin
      count_next = count + QCNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  `WFD_ASSERT_NEVER(a_no_push_full, clk, rst, push && qstat.full, "push into full queue")
  `WFD_ASSERT_NEVER(a_no_pop_empty, clk, rst, pop && qstat.empty, "pop from empty queue")
  `WFD_ASSERT(a_count_bound, clk, rst, count <= QCNT_W'(QDEPTH), "queue count out of range")

endmodule

`default_nettype wire

[rtl/core/wfd_out.sv]
// ----------------------------------------------------------------------------
// wfd_out
// Back end: drains the queue, unmasks payload bytes and holds the result
// transaction in the output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module wfd_out
  import wfd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire qstat_t qstat,
  input  wire entry_t pop_entry,
  output logic        pop,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic [2:0]  result_kind,
  output logic [7:0]  data_byte,
  output logic [3:0]  frame_opcode,
  output logic        last
);

  assign pop = !qstat.empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result_kind  <= 3'(pop_entry.kind);
      data_byte    <= pop_entry.raw ^ pop_entry.key;
      frame_opcode <= pop_entry.opcode;
      last         <= pop_entry.last;
    end
  end

endmodule

`default_nettype wire
